// ===== src/monotone_table_dithered_lookup_core_macros.svh =====
// Assertion helpers for the checker file.
`ifndef MONOTONE_TABLE_DITHERED_LOOKUP_CORE_MACROS_SVH
`define MONOTONE_TABLE_DITHERED_LOOKUP_CORE_MACROS_SVH

// Property checked only outside reset.
`define MTDL_ASSERT_ON(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked at every edge, reset included.
`define MTDL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/mtdl_pkg.sv =====
`default_nettype none
package mtdl_pkg;

  localparam int VALUE_BITS         = 32;
  localparam int FRACTION_BITS      = 16;
  localparam int INDEX_BITS         = 6;
  localparam int COUNT_BITS         = 7;
  localparam int MAX_POINTS_DEFAULT = 64;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_CONVERT = 1'b1;

  typedef struct packed {
    logic                            action;
    logic [INDEX_BITS-1:0]           point_index;
    logic signed [VALUE_BITS-1:0]    x_value;
    logic signed [VALUE_BITS-1:0]    y_value;
    logic signed [VALUE_BITS-1:0]    query_value;
    logic [FRACTION_BITS-1:0]        random_fraction;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] converted_value;
    logic                         in_range;
  } out_item_t;

  typedef enum logic [1:0] {
    XS_FIRST,
    XS_LAST,
    XS_SCAN
  } xsel_t;

  typedef enum logic {
    YS_LOWER,
    YS_UPPER
  } ysel_t;

  typedef struct packed {
    logic  capture;
    logic  load_wr;
    xsel_t x_sel;
    ysel_t y_sel;
    logic  save_x0;
    logic  save_xl;
    logic  idx_init;
    logic  idx_inc;
    logic  save_lower;
    logic  save_diff;
    logic  do_mul;
    logic  do_add;
    logic  set_invalid;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic is_convert;
    logic short_table;
    logic out_of_range;
    logic scan_hit;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== src/mtdl_ctrl.sv =====
`default_nettype none
module mtdl_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire mtdl_pkg::status_t status,
  output mtdl_pkg::cmd_t       cmd
);
  import mtdl_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_RD_FIRST  = 4'd1;
  localparam logic [3:0] S_RD_LAST   = 4'd2;
  localparam logic [3:0] S_SAVE_LAST = 4'd3;
  localparam logic [3:0] S_RANGE     = 4'd4;
  localparam logic [3:0] S_SCAN_ADDR = 4'd5;
  localparam logic [3:0] S_SCAN_CMP  = 4'd6;
  localparam logic [3:0] S_RD_LO     = 4'd7;
  localparam logic [3:0] S_RD_HI     = 4'd8;
  localparam logic [3:0] S_DIFF      = 4'd9;
  localparam logic [3:0] S_MUL       = 4'd10;
  localparam logic [3:0] S_ADD       = 4'd11;
  localparam logic [3:0] S_FINISH    = 4'd12;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.x_sel  = XS_FIRST;
    cmd.y_sel  = YS_LOWER;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (status.is_convert) begin
            state_next = S_RD_FIRST;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      S_RD_FIRST: begin
        cmd.x_sel = XS_FIRST;
        if (status.short_table) begin
          cmd.set_invalid = 1'b1;
          state_next      = S_FINISH;
        end else begin
          state_next = S_RD_LAST;
        end
      end
      S_RD_LAST: begin
        cmd.x_sel   = XS_LAST;
        cmd.save_x0 = 1'b1;
        state_next  = S_SAVE_LAST;
      end
      S_SAVE_LAST: begin
        cmd.save_xl = 1'b1;
        state_next  = S_RANGE;
      end
      S_RANGE: begin
        if (status.out_of_range) begin
          cmd.set_invalid = 1'b1;
          state_next      = S_FINISH;
        end else begin
          cmd.idx_init = 1'b1;
          state_next   = S_SCAN_ADDR;
        end
      end
      S_SCAN_ADDR: begin
        cmd.x_sel  = XS_SCAN;
        state_next = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (status.scan_hit) begin
          state_next = S_RD_LO;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SCAN_ADDR;
        end
      end
      S_RD_LO: begin
        cmd.y_sel  = YS_LOWER;
        state_next = S_RD_HI;
      end
      S_RD_HI: begin
        cmd.y_sel      = YS_UPPER;
        cmd.save_lower = 1'b1;
        state_next     = S_DIFF;
      end
      S_DIFF: begin
        cmd.save_diff = 1'b1;
        state_next    = S_MUL;
      end
      S_MUL: begin
        cmd.do_mul = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.do_add = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/mtdl_datapath.sv =====
`default_nettype none
module mtdl_datapath #(
  parameter int MAX_POINTS = mtdl_pkg::MAX_POINTS_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [mtdl_pkg::COUNT_BITS-1:0]  cfg_data,
  input  wire mtdl_pkg::in_item_t               in_item,
  input  wire mtdl_pkg::cmd_t                   cmd,
  output mtdl_pkg::status_t                     status,
  input  wire logic                             out_ready,
  output logic                                  out_valid,
  output mtdl_pkg::out_item_t                   out_item
);
  import mtdl_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int EW = (AW > INDEX_BITS) ? AW : INDEX_BITS;
  localparam int CW = (NW > COUNT_BITS) ? NW : COUNT_BITS;
  localparam int PW = VALUE_BITS + FRACTION_BITS + 2;

  logic [COUNT_BITS-1:0] point_count;

  logic signed [VALUE_BITS-1:0] x_mem [MAX_POINTS];
  logic signed [VALUE_BITS-1:0] y_mem [MAX_POINTS];

  logic signed [VALUE_BITS-1:0] query;
  logic [FRACTION_BITS-1:0]     frac;
  logic [NW-1:0]                n;
  logic [AW-1:0]                idx;
  logic signed [VALUE_BITS-1:0] x0, xl, x_rd, y_rd, lower;
  logic signed [VALUE_BITS:0]   diff;
  logic signed [PW-1:0]         prod;
  logic signed [VALUE_BITS-1:0] result;
  logic                         result_ok;

  logic [EW-1:0]   wr_ext;
  logic [AW-1:0]   wr_addr;
  logic [CW-1:0]   count_ext;
  logic [NW-1:0]   n_clamped;
  logic [AW-1:0]   x_addr, y_addr;
  logic [NW-1:0]   last_slot;
  logic            reversed;
  logic signed [VALUE_BITS-1:0] first_x, last_x;
  logic signed [PW-1:0]         prod_shr;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] i, input logic [NW-1:0] cnt,
                                         input logic rev);
    logic [NW-1:0] back;
    back = cnt - NW'(1) - NW'(i);
    return rev ? back[AW-1:0] : i;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (cfg_we) begin
      point_count <= cfg_data;
    end
  end

  assign wr_ext    = EW'(in_item.point_index);
  assign wr_addr   = wr_ext[AW-1:0];
  assign count_ext = CW'(point_count);
  assign n_clamped = (int'(point_count) > MAX_POINTS) ? NW'(MAX_POINTS) : count_ext[NW-1:0];

  assign last_slot = n - NW'(1);
  assign reversed  = x0 > xl;
  assign first_x   = reversed ? xl : x0;
  assign last_x    = reversed ? x0 : xl;

  always_comb begin
    unique case (cmd.x_sel)
      XS_FIRST: x_addr = '0;
      XS_LAST:  x_addr = last_slot[AW-1:0];
      XS_SCAN:  x_addr = slot(idx, n, reversed);
      default:  x_addr = '0;
    endcase
    unique case (cmd.y_sel)
      YS_LOWER: y_addr = slot(idx - AW'(1), n, reversed);
      YS_UPPER: y_addr = slot(idx, n, reversed);
      default:  y_addr = '0;
    endcase
  end

  // table memories, one write and one registered read port each
  always_ff @(posedge clk) begin
    if (cmd.load_wr && (int'(in_item.point_index) < MAX_POINTS)) begin
      x_mem[wr_addr] <= in_item.x_value;
      y_mem[wr_addr] <= in_item.y_value;
    end
  end

  always_ff @(posedge clk) begin
    x_rd <= x_mem[x_addr];
    y_rd <= y_mem[y_addr];
  end

  assign prod_shr = prod >>> FRACTION_BITS;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      query <= in_item.query_value;
      frac  <= in_item.random_fraction;
      n     <= n_clamped;
    end
    if (cmd.save_x0) x0 <= x_rd;
    if (cmd.save_xl) xl <= x_rd;
    if (cmd.idx_init) begin
      idx <= AW'(1);
    end else if (cmd.idx_inc) begin
      idx <= idx + AW'(1);
    end
    if (cmd.save_lower) lower <= y_rd;
    if (cmd.save_diff) diff <= (VALUE_BITS+1)'(y_rd) - (VALUE_BITS+1)'(lower);
    if (cmd.do_mul) prod <= PW'(diff) * PW'($signed({1'b0, frac}));
    if (cmd.set_invalid) begin
      result    <= '0;
      result_ok <= 1'b0;
    end else if (cmd.do_add) begin
      // result lies between lower and upper, so the low bits are exact
      result    <= lower + prod_shr[VALUE_BITS-1:0];
      result_ok <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item.converted_value <= result;
      out_item.in_range        <= result_ok;
    end
  end

  assign status.is_convert   = in_item.action == ACT_CONVERT;
  assign status.short_table  = n < NW'(2);
  assign status.out_of_range = (query < first_x) || (query >= last_x);
  // last logical x is known to exceed the query, so the scan ends there
  assign status.scan_hit     = (x_rd > query) || (NW'(idx) == last_slot);
  assign status.out_free     = !out_valid || out_ready;

endmodule
`default_nettype wire

// ===== src/monotone_table_dithered_lookup_core.sv =====
// Breakpoint table lookup with dithered interpolation.
//
// Input channel (in_valid/in_ready/in_item): a load item writes one (x, y)
// pair into a table slot; a convert item looks up query_value in the table.
// Output channel (out_valid/out_ready/out_item): one item per convert, none
// per load. cfg_we/cfg_data set point_count; the user must do this only while
// the block is idle, which the block itself does not enforce.
// A load is written when accepted; the next item is taken right after it.
// A convert reads the first and last x and checks the query range, scans the
// x memory from logical slot 1 to the first x above the query (1..n-1), one
// registered read and compare per step, then reads the lower and upper y and
// forms difference, product and sum; a query outside the table or a table
// under two points ends early. Only one item is in work at a time.
//
// Reset clears point_count and out_valid; the table memories are
// undefined until loaded. If out_ready is low the result waits in the output
// register and the block holds the finished convert until it is taken.
`default_nettype none
module monotone_table_dithered_lookup_core #(
  parameter int MAX_POINTS = mtdl_pkg::MAX_POINTS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [mtdl_pkg::COUNT_BITS-1:0] cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire mtdl_pkg::in_item_t              in_item,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output mtdl_pkg::out_item_t                  out_item
);
  import mtdl_pkg::*;

  cmd_t    cmd;
  status_t status;

  mtdl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mtdl_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// ===== src/mtdl_checker.sv =====
`default_nettype none
`include "monotone_table_dithered_lookup_core_macros.svh"
module mtdl_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire mtdl_pkg::in_item_t  in_item,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire mtdl_pkg::out_item_t out_item
);
  import mtdl_pkg::*;

  `MTDL_ASSERT_ON(a_convert_busy, (in_valid && in_ready && in_item.action == ACT_CONVERT) |=> !in_ready, "convert item accepted while not busy next cycle")
  `MTDL_ASSERT_ON(a_load_single, (in_valid && in_ready && in_item.action == ACT_LOAD) |=> in_ready, "load item held the input channel")
  `MTDL_ASSERT_ON(a_invalid_zero, (out_valid && !out_item.in_range) |-> (out_item.converted_value == '0), "out of range result not zero")
  `MTDL_ASSERT_ON(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_item)), "stalled result item changed")
  `MTDL_ASSERT_ALWAYS(a_reset_out, rst |=> !out_valid, "output valid after reset")

endmodule

bind monotone_table_dithered_lookup_core mtdl_checker u_mtdl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
`default_nettype wire
